FILE: design/present_pkg.sv
// present_pkg: shared constants, types and layer functions of the PRESENT core
// depends on nothing; imported by every module of the core
`default_nettype none

package present_pkg;

  localparam int unsigned ROUNDS     = 31;
  localparam int unsigned KEY_SLOTS  = 32;
  localparam int unsigned KEY_ADDR_W = 5;
  localparam int unsigned BLOCK_W    = 64;
  localparam int unsigned PERM_MOD   = 63;

  localparam logic [BLOCK_W-1:0] SBOX_FWD = 64'h21748FE3DA09B65C;
  localparam logic [BLOCK_W-1:0] SBOX_INV = 64'hA970364BD21C8FE5;

  localparam logic [KEY_ADDR_W-1:0] LAST_ROUND_KEY = KEY_ADDR_W'(ROUNDS);
  localparam logic [KEY_ADDR_W-1:0] LAST_ROUND_IDX = KEY_ADDR_W'(ROUNDS - 1);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic                  wr_en;
    logic [KEY_ADDR_W-1:0] wr_addr;
    logic                  rd_en;
    logic [KEY_ADDR_W-1:0] rd_addr;
  } key_ram_req_t;

  function automatic logic [5:0] perm_pos(input int unsigned i);
    if (i == PERM_MOD) begin
      return 6'(PERM_MOD);
    end
    return 6'((16 * i) % PERM_MOD);
  endfunction

  function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] v,
                                                     input logic [BLOCK_W-1:0] tbl);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = tbl[{v[4*n +: 4], 2'b00} +: 4];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] p_layer(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < BLOCK_W; i++) begin
      r[perm_pos(i)] = v[i];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] p_layer_inv(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < BLOCK_W; i++) begin
      r[i] = v[perm_pos(i)];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/present_key_ram.sv
// present_key_ram: 32 x 64 round key store, one write and one registered read port
// depends on present_pkg
`default_nettype none

module present_key_ram (
  input  wire logic                            clk,
  input  wire present_pkg::key_ram_req_t       req,
  input  wire logic [present_pkg::BLOCK_W-1:0] wr_data,
  output logic      [present_pkg::BLOCK_W-1:0] rd_data
);
  import present_pkg::*;

  logic [BLOCK_W-1:0] mem [KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/present_round.sv
// present_round: one PRESENT round, forward or inverse, key addition included
// depends on present_pkg
`default_nettype none

module present_round (
  input  wire logic [present_pkg::BLOCK_W-1:0] block_in,
  input  wire logic [present_pkg::BLOCK_W-1:0] round_key,
  input  wire logic                            decrypt,
  output logic      [present_pkg::BLOCK_W-1:0] block_res
);
  import present_pkg::*;

  logic [BLOCK_W-1:0] keyed;

  always_comb begin
    keyed = block_in ^ round_key;
    if (decrypt) begin
      block_res = sbox_layer(p_layer_inv(keyed), SBOX_INV);
    end else begin
      block_res = p_layer(sbox_layer(keyed, SBOX_FWD));
    end
  end

endmodule

`default_nettype wire

FILE: design/present_block_cipher_core.sv
// present_block_cipher_core: top level, sequencer around key store and round unit
// depends on present_pkg, present_key_ram, present_round
//
// channel | signals                              | direction
// in      | in_valid in_stall operation key_slot data_word | into core
// out     | out_valid out_stall block_out        | out of core
//
// a load item is written to the key store when taken and does not make the core busy;
// encrypt or decrypt issues the first key read, then runs 31 rounds, then the final key addition
// the key store read port gives one round key per cycle and sets that pace
// the result sits in an output register, so a new item is taken while it waits
// synchronous reset returns the sequencer to idle and drops out_valid
// key store contents are not cleared by reset
`default_nettype none

module present_block_cipher_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      operation,
  input  wire logic [present_pkg::KEY_ADDR_W-1:0] key_slot,
  input  wire logic [present_pkg::BLOCK_W-1:0] data_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [present_pkg::BLOCK_W-1:0] block_out
);
  import present_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINAL
  } state_t;

  state_t             state;
  logic [BLOCK_W-1:0] blk;
  logic               dec;
  logic [KEY_ADDR_W-1:0] kidx;
  logic [KEY_ADDR_W-1:0] rnd;
  logic               accept;
  logic               start;
  op_t                op;
  key_ram_req_t       req;
  logic [BLOCK_W-1:0] key;
  logic [BLOCK_W-1:0] round_out;

  assign op       = op_t'(operation);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (op == OP_ENCRYPT || op == OP_DECRYPT);

  always_comb begin
    req.wr_en   = accept && (op == OP_LOAD);
    req.wr_addr = key_slot;
    req.rd_en   = 1'b0;
    req.rd_addr = kidx;
    case (state)
      ST_IDLE: begin
        req.rd_en   = start;
        req.rd_addr = (op == OP_DECRYPT) ? LAST_ROUND_KEY : '0;
      end
      ST_RUN: begin
        req.rd_en   = 1'b1;
        req.rd_addr = dec ? kidx - 1'b1 : kidx + 1'b1;
      end
      default: begin
        req.rd_en = 1'b0;
      end
    endcase
  end

  present_key_ram u_key_ram (
    .clk     (clk),
    .req     (req),
    .wr_data (data_word),
    .rd_data (key)
  );

  present_round u_round (
    .block_in  (blk),
    .round_key (key),
    .decrypt   (dec),
    .block_res (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FINAL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            blk   <= data_word;
            dec   <= (op == OP_DECRYPT);
            kidx  <= req.rd_addr;
            rnd   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          blk  <= round_out;
          kidx <= req.rd_addr;
          rnd  <= rnd + 1'b1;
          if (rnd == LAST_ROUND_IDX) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!out_valid || !out_stall) begin
            block_out <= blk ^ key;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/present_core_checker.sv
// present_core_checker: port-level checks of the PRESENT core, bound to the top level
// depends on present_pkg and present_block_cipher_core
`default_nettype none

module present_core_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [1:0]                      operation,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [present_pkg::BLOCK_W-1:0] block_out
);
  import present_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (operation == OP_ENCRYPT || operation == OP_DECRYPT) |=> in_stall)
    else $error("block item did not make core busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_acc && (operation == OP_LOAD || operation == OP_NONE) |=> !in_stall)
    else $error("load item stalled the input");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_out))
    else $error("stalled result changed");

endmodule

bind present_block_cipher_core present_core_checker u_present_core_checker (.*);

`default_nettype wire
